@@ rtl/bfr_pkg.sv @@
// package: types, codes and sizes shared by the bit reader modules
package bfr_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_UBITS  = 3'd1;
    localparam logic [2:0] CMD_SBITS  = 3'd2;
    localparam logic [2:0] CMD_ALIGN  = 3'd3;
    localparam logic [2:0] CMD_LEU    = 3'd4;
    localparam logic [2:0] CMD_LES    = 3'd5;
    localparam logic [2:0] CMD_VARINT = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNDERRUN = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [5:0] MAX_BITS  = 6'd32;
    localparam logic [3:0] MAX_BYTES = 4'd8;
    localparam logic [2:0] MAX_VARINT_BYTES = 3'd5;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] byte_in;
        logic [5:0] bit_count;
        logic [3:0] byte_count;
    } req_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } rsp_t;

    // top -> sequencer control
    typedef struct packed {
        logic start;
        logic slot_free;
    } seq_ctrl_t;

    // sequencer -> top status
    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

endpackage

@@ rtl/bfr_ram.sv @@
// generic single write port, single read port ram with registered read
module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bfr_seq.sv @@
// request sequencer: reader state, byte fetch loop and result assembly
module bfr_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bfr_pkg::seq_ctrl_t          ctrl,
    input  bfr_pkg::req_t               req,
    output bfr_pkg::seq_stat_t          stat,
    output bfr_pkg::rsp_t               res,
    output logic                        ram_we,
    output logic [bfr_pkg::ADDR_W-1:0]  ram_waddr,
    output logic [7:0]                  ram_wdata,
    output logic                        ram_re,
    output logic [bfr_pkg::ADDR_W-1:0]  ram_raddr,
    input  logic [7:0]                  ram_rdata
);

    import bfr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic [CNT_W-1:0] rd_pos_reg, rd_pos_next;
    logic [2:0]       bit_pos_reg, bit_pos_next;
    logic [7:0]       cur_byte_reg, cur_byte_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [5:0]       n_reg, n_next;
    logic [2:0]       shift_reg, shift_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0] fptr_reg, fptr_next;
    logic [3:0]       left_reg, left_next;
    logic             rvalid_reg, rvalid_next;
    logic [2:0]       idx_reg, idx_next;
    logic [7:0]       last_byte_reg, last_byte_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      res_value_reg, res_value_next;
    logic [1:0]       res_status_reg, res_status_next;

    // start decode
    logic [5:0]       n_sat;
    logic [3:0]       cnt_sat;
    logic [3:0]       avail;
    logic [5:0]       more;
    logic [2:0]       k;
    logic [5:0]       total;
    logic [7:0]       cur_mask;
    logic [CNT_W-1:0] space;
    logic [3:0]       vlen;

    // fetch loop
    logic [5:0]       le_pos;
    logic [5:0]       vi_pos;
    logic [63:0]      bits_val;
    logic [63:0]      le_val;
    logic [5:0]       le_sign_idx;
    logic [6:0]       le_width;
    logic             done_pulse;

    always_comb
    begin
        n_sat    = (req.bit_count > MAX_BITS) ? MAX_BITS : req.bit_count;
        cnt_sat  = (req.byte_count > MAX_BYTES) ? MAX_BYTES : req.byte_count;
        avail    = (bit_pos_reg == 3'd0) ? 4'd0 : 4'd8 - {1'b0, bit_pos_reg};
        more     = (n_sat > {2'b00, avail}) ? n_sat - {2'b00, avail} : 6'd0;
        k        = 3'(({1'b0, more} + 7'd7) >> 3);
        total    = {2'b00, avail} + {k, 3'b000};
        cur_mask = (bit_pos_reg == 3'd0) ? 8'd0 : (cur_byte_reg & (8'hFF >> bit_pos_reg));
        space    = loaded_reg - rd_pos_reg;
        vlen     = (space > CNT_W'(MAX_VARINT_BYTES)) ? {1'b0, MAX_VARINT_BYTES}
                                                      : space[3:0];
    end

    always_comb
    begin
        le_pos      = {idx_reg, 3'b000};
        vi_pos      = 6'(idx_reg) * 6'd7;
        bits_val    = acc_reg >> shift_reg;
        if (cmd_reg == CMD_SBITS && bits_val[n_reg - 6'd1])
        begin
            bits_val = bits_val | ~((64'd1 << n_reg) - 64'd1);
        end
        le_width    = {cnt_reg, 3'b000};
        le_sign_idx = 6'(le_width - 7'd1);
        le_val      = acc_reg;
        if (cmd_reg == CMD_LES && cnt_reg != 4'd0 && acc_reg[le_sign_idx])
        begin
            le_val = acc_reg | ~((64'd1 << le_width) - 64'd1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        rd_pos_next     = rd_pos_reg;
        bit_pos_next    = bit_pos_reg;
        cur_byte_next   = cur_byte_reg;
        cmd_next        = cmd_reg;
        n_next          = n_reg;
        shift_next      = shift_reg;
        cnt_next        = cnt_reg;
        fptr_next       = fptr_reg;
        left_next       = left_reg;
        rvalid_next     = 1'b0;
        idx_next        = idx_reg;
        last_byte_next  = last_byte_reg;
        acc_next        = acc_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        done_pulse      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    cmd_next        = req.cmd;
                    res_value_next  = 64'd0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    case (req.cmd)
                        CMD_LOAD:
                        begin
                            if (loaded_reg == DEPTH_CNT)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                loaded_next = loaded_reg + CNT_W'(1);
                            end
                        end
                        CMD_UBITS, CMD_SBITS:
                        begin
                            if (n_sat != 6'd0)
                            begin
                                if (CNT_W'(k) > space)
                                begin
                                    res_status_next = ST_UNDERRUN;
                                end
                                else
                                begin
                                    acc_next       = {56'd0, cur_mask};
                                    left_next      = {1'b0, k};
                                    fptr_next      = rd_pos_reg;
                                    n_next         = n_sat;
                                    shift_next     = 3'(total - n_sat);
                                    last_byte_next = cur_byte_reg;
                                    state_next     = S_FETCH;
                                end
                            end
                        end
                        CMD_ALIGN:
                        begin
                            bit_pos_next = 3'd0;
                        end
                        CMD_LEU, CMD_LES:
                        begin
                            if (CNT_W'(cnt_sat) > space)
                            begin
                                res_status_next = ST_UNDERRUN;
                            end
                            else
                            begin
                                acc_next   = 64'd0;
                                left_next  = cnt_sat;
                                cnt_next   = cnt_sat;
                                idx_next   = 3'd0;
                                fptr_next  = rd_pos_reg;
                                state_next = S_FETCH;
                            end
                        end
                        CMD_VARINT:
                        begin
                            acc_next   = 64'd0;
                            left_next  = vlen;
                            idx_next   = 3'd0;
                            fptr_next  = rd_pos_reg;
                            state_next = S_FETCH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                // one read issued per cycle, data consumed the cycle after
                if (left_reg != 4'd0)
                begin
                    ram_re      = 1'b1;
                    fptr_next   = fptr_reg + CNT_W'(1);
                    left_next   = left_reg - 4'd1;
                    rvalid_next = 1'b1;
                end

                if (cmd_reg == CMD_VARINT)
                begin
                    if (rvalid_reg)
                    begin
                        acc_next[vi_pos +: 7] = ram_rdata[6:0];
                        idx_next = idx_reg + 3'd1;
                        if (!ram_rdata[7] || idx_reg == MAX_VARINT_BYTES - 3'd1)
                        begin
                            res_value_next = {32'd0, acc_next[31:0]};
                            rd_pos_next    = rd_pos_reg + CNT_W'(idx_next);
                            bit_pos_next   = 3'd0;
                            rvalid_next    = 1'b0;
                            state_next     = S_DONE;
                        end
                    end
                    else if (left_reg == 4'd0)
                    begin
                        res_status_next = ST_UNDERRUN;
                        state_next      = S_DONE;
                    end
                end
                else if (rvalid_reg)
                begin
                    if (cmd_reg == CMD_UBITS || cmd_reg == CMD_SBITS)
                    begin
                        acc_next       = {acc_reg[55:0], ram_rdata};
                        last_byte_next = ram_rdata;
                    end
                    else
                    begin
                        acc_next[le_pos +: 8] = ram_rdata;
                        idx_next = idx_reg + 3'd1;
                    end
                end
                else if (left_reg == 4'd0)
                begin
                    rd_pos_next = fptr_reg;
                    state_next  = S_DONE;
                    if (cmd_reg == CMD_UBITS || cmd_reg == CMD_SBITS)
                    begin
                        res_value_next = bits_val;
                        bit_pos_next   = bit_pos_reg + n_reg[2:0];
                        cur_byte_next  = last_byte_reg;
                    end
                    else
                    begin
                        res_value_next = le_val;
                        bit_pos_next   = 3'd0;
                    end
                end
            end

            S_DONE:
            begin
                if (ctrl.slot_free)
                begin
                    done_pulse = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            loaded_reg   <= '0;
            rd_pos_reg   <= '0;
            bit_pos_reg  <= '0;
            cur_byte_reg <= '0;
            rvalid_reg   <= 1'b0;
            left_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            rd_pos_reg   <= rd_pos_next;
            bit_pos_reg  <= bit_pos_next;
            cur_byte_reg <= cur_byte_next;
            rvalid_reg   <= rvalid_next;
            left_reg     <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        n_reg          <= n_next;
        shift_reg      <= shift_next;
        cnt_reg        <= cnt_next;
        fptr_reg       <= fptr_next;
        idx_reg        <= idx_next;
        last_byte_reg  <= last_byte_next;
        acc_reg        <= acc_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    assign ram_waddr = loaded_reg[ADDR_W-1:0];
    assign ram_wdata = req.byte_in;
    assign ram_raddr = fptr_reg[ADDR_W-1:0];

    assign stat.idle  = (state_reg == S_IDLE);
    assign stat.done  = done_pulse;
    assign res.value  = res_value_reg;
    assign res.status = res_status_reg;

    a_pos_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pos_reg <= loaded_reg)
        else $error("read position passed loaded count");

    a_loaded_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= DEPTH_CNT)
        else $error("loaded count passed buffer depth");

    a_read_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (fptr_reg < loaded_reg))
        else $error("buffer read of a byte not loaded");

    a_full_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (done_pulse && res_status_reg == ST_FULL) |-> (cmd_reg == CMD_LOAD))
        else $error("full status on a request other than load");

    a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (loaded_reg == $past(loaded_reg) + CNT_W'(1)))
        else $error("buffer write without loaded count step");

endmodule

@@ rtl/bitstream_field_reader.sv @@
// top level: request/response channels around the bit reader sequencer and byte buffer
// The reader takes one request at a time on the req channel and returns exactly one
// transfer on the rsp channel for each, holding a byte buffer of BUFFER_DEPTH entries
// in a single ram with a registered read port. A load or align request completes
// without reading the buffer; a bit field or little-endian request fetches its
// buffer bytes through the one read port, which delivers one byte per cycle while
// bytes remain to fetch. A varint ends in the cycle its last byte arrives, after at
// most MAX_VARINT_BYTES bytes; a varint that runs out of loaded bytes, or finds none
// left, returns an underrun. Refused bit field and little-endian requests (underrun)
// and zero-width fields skip the fetch. Results wait in an output register, so the next
// request is taken while an earlier response is still unclaimed; the sequencer only
// stalls when a second result is ready and the register is still occupied. Requests
// never overlap, and a load writes the buffer in the cycle it is accepted, so no
// read can meet a write to the same entry and no forwarding is needed.
module bitstream_field_reader (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  bfr_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output bfr_pkg::rsp_t   rsp
);

    import bfr_pkg::*;

    seq_ctrl_t          ctrl;
    seq_stat_t          stat;
    rsp_t               res;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;

    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    // a request transfers whenever the sequencer sits idle
    assign req_ready      = stat.idle;
    assign ctrl.start     = req_valid && stat.idle;
    // the output register can take a result if empty or being drained now
    assign ctrl.slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (stat.done)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    bfr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .req       (req),
        .stat      (stat),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // loaded bytes, written at the load count, read at the fetch pointer
    bfr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    a_done_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (!rsp_valid_reg || rsp_ready))
        else $error("result produced while output register held");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !stat.idle)
        else $error("sequencer stayed idle after request transfer");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> (stat.idle && rsp_valid_reg))
        else $error("result transfer not registered");

endmodule
